// ----- rtl/acm_pkg.sv -----
`default_nettype none
package acm_pkg;

  // ring of recent samples and floor mean by reciprocal multiply
  localparam int AVG_DEPTH  = 10;
  localparam int POS_W      = 4;
  localparam int SUM_W      = 16;
  localparam logic [15:0] MEAN_RECIP = 16'd52429;
  localparam int MEAN_SHIFT = 19;

  // scaling constants
  localparam logic [6:0]  AMP_GAIN  = 7'd59;
  localparam logic [19:0] UA_PER_A  = 20'd1000000;
  localparam logic [15:0] TICK_MS   = 16'd10;
  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  // arithmetic widths
  localparam int NUM_W = 44;
  localparam int DEN_W = 38;
  localparam int CNT_W = 6;

  // range codes
  localparam logic [1:0] RANGE_LOW  = 2'd0;
  localparam logic [1:0] RANGE_MID  = 2'd1;
  localparam logic [1:0] RANGE_HIGH = 2'd2;
  localparam logic [1:0] RANGE_OVF  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_REF_ZERO = 2'd2;

  // register indexes
  localparam logic [2:0] REG_LOW_MOHM  = 3'd0;
  localparam logic [2:0] REG_MID_MOHM  = 3'd1;
  localparam logic [2:0] REG_HIGH_MOHM = 3'd2;
  localparam logic [2:0] REG_REF_MV    = 3'd3;
  localparam logic [2:0] REG_UP_TH     = 3'd4;
  localparam logic [2:0] REG_DOWN_TH   = 3'd5;
  localparam logic [2:0] REG_RECOVERY  = 3'd6;
  localparam logic [2:0] REG_SETTLE    = 3'd7;

  // controller commands to the datapath
  typedef struct packed {
    logic accept;
    logic ring;
    logic mean;
    logic mul1;
    logic mul2;
    logic decide;
    logic load_out;
  } cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/acm_div.sv -----
`default_nettype none
module acm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [acm_pkg::NUM_W-1:0]  dividend,
  input  wire logic [acm_pkg::DEN_W-1:0]  divisor,
  output logic                            done,
  output logic [acm_pkg::NUM_W-1:0]       quotient
);

  logic                       busy;
  logic [acm_pkg::CNT_W-1:0]  cnt;
  logic [acm_pkg::DEN_W:0]    rem;
  logic [acm_pkg::DEN_W-1:0]  dvs;
  logic [acm_pkg::DEN_W:0]    trial;
  logic                       take;

  // one quotient bit per cycle, restoring
  assign trial = {rem[acm_pkg::DEN_W-1:0], quotient[acm_pkg::NUM_W-1]};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == acm_pkg::CNT_W'(acm_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? (trial - {1'b0, dvs}) : trial;
      quotient <= {quotient[acm_pkg::NUM_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/acm_ctrl.sv -----
`default_nettype none
module acm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire acm_pkg::stat_t stat,
  output acm_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RING, S_MEAN, S_MUL1, S_MUL2, S_DECIDE, S_DIV, S_FIN
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.ring     = (state == S_RING);
    cmd.mean     = (state == S_MEAN);
    cmd.mul1     = (state == S_MUL1);
    cmd.mul2     = (state == S_MUL2);
    cmd.decide   = (state == S_DECIDE);
    cmd.load_out = (state == S_FIN) && stat.out_free;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (in_valid) state <= S_RING;
        S_RING:   state <= S_MEAN;
        S_MEAN:   state <= S_MUL1;
        S_MUL1:   state <= S_MUL2;
        S_MUL2:   state <= S_DECIDE;
        S_DECIDE: state <= S_DIV;
        S_DIV:    if (stat.div_done) state <= S_FIN;
        S_FIN:    if (stat.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/acm_datapath.sv -----
`default_nettype none
module acm_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire acm_pkg::cmd_t cmd,
  output acm_pkg::stat_t     stat,
  input  wire logic [11:0]   current_sample,
  input  wire logic [11:0]   ref_sample,
  input  wire logic          bypass,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        current_ua,
  output logic [1:0]         range_now,
  output logic [2:0]         relays,
  output logic [1:0]         status,
  input  wire logic          cfg_write,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output logic [31:0]        cfg_rdata
);

  // configuration registers
  logic [19:0] low_mohm, mid_mohm, high_mohm;
  logic [11:0] ref_mv, up_th, down_th;
  logic [9:0]  recovery_ms, settle_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_mohm    <= 20'd52000;
      mid_mohm    <= 20'd510;
      high_mohm   <= 20'd6;
      ref_mv      <= 12'd2048;
      up_th       <= 12'd3900;
      down_th     <= 12'd30;
      recovery_ms <= 10'd100;
      settle_ms   <= 10'd100;
    end else if (cfg_write) begin
      case (cfg_index)
        acm_pkg::REG_LOW_MOHM:  low_mohm    <= cfg_data[19:0];
        acm_pkg::REG_MID_MOHM:  mid_mohm    <= cfg_data[19:0];
        acm_pkg::REG_HIGH_MOHM: high_mohm   <= cfg_data[19:0];
        acm_pkg::REG_REF_MV:    ref_mv      <= cfg_data[11:0];
        acm_pkg::REG_UP_TH:     up_th       <= cfg_data[11:0];
        acm_pkg::REG_DOWN_TH:   down_th     <= cfg_data[11:0];
        acm_pkg::REG_RECOVERY:  recovery_ms <= cfg_data[9:0];
        acm_pkg::REG_SETTLE:    settle_ms   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_index)
      acm_pkg::REG_LOW_MOHM:  cfg_rdata = {12'd0, low_mohm};
      acm_pkg::REG_MID_MOHM:  cfg_rdata = {12'd0, mid_mohm};
      acm_pkg::REG_HIGH_MOHM: cfg_rdata = {12'd0, high_mohm};
      acm_pkg::REG_REF_MV:    cfg_rdata = {20'd0, ref_mv};
      acm_pkg::REG_UP_TH:     cfg_rdata = {20'd0, up_th};
      acm_pkg::REG_DOWN_TH:   cfg_rdata = {20'd0, down_th};
      acm_pkg::REG_RECOVERY:  cfg_rdata = {22'd0, recovery_ms};
      acm_pkg::REG_SETTLE:    cfg_rdata = {22'd0, settle_ms};
      default:                cfg_rdata = '0;
    endcase
  end

  // input item capture
  logic [11:0] smp, refs;
  logic        byp;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp  <= current_sample;
      refs <= ref_sample;
      byp  <= bypass;
    end
  end

  // sample ring with running sum
  logic [11:0]                     ring [acm_pkg::AVG_DEPTH];
  logic [acm_pkg::POS_W-1:0]       pos;
  logic [acm_pkg::SUM_W-1:0]       sum;
  logic [11:0]                     mean;
  logic [acm_pkg::SUM_W+15:0]      mean_prod;

  assign mean_prod = sum * acm_pkg::MEAN_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
      for (int i = 0; i < acm_pkg::AVG_DEPTH; i++) ring[i] <= '0;
    end else if (cmd.ring) begin
      ring[pos] <= smp;
      sum       <= sum - acm_pkg::SUM_W'(ring[pos]) + acm_pkg::SUM_W'(smp);
      pos       <= (pos == acm_pkg::POS_W'(acm_pkg::AVG_DEPTH - 1)) ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean) mean <= 12'(mean_prod >> acm_pkg::MEAN_SHIFT);
  end

  // control state
  logic [1:0]  active_range, prior_range;
  logic        overflowed;
  logic [2:0]  waiting;
  logic [15:0] timer [3];
  logic [2:0]  drive;

  // numerator and denominator products
  logic [23:0]                num_a;
  logic [17:0]                den_a;
  logic [acm_pkg::NUM_W-1:0]  num;
  logic [acm_pkg::DEN_W-1:0]  den;
  logic [19:0]                shunt;

  always_comb begin
    case (active_range)
      acm_pkg::RANGE_LOW: shunt = low_mohm;
      acm_pkg::RANGE_MID: shunt = mid_mohm;
      default:            shunt = high_mohm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      num_a <= 24'(mean) * 24'(ref_mv);
      den_a <= 18'(refs) * 18'(acm_pkg::AMP_GAIN);
    end
    if (cmd.mul2) begin
      num <= acm_pkg::NUM_W'(num_a) * acm_pkg::NUM_W'(acm_pkg::UA_PER_A);
      den <= acm_pkg::DEN_W'(den_a) * acm_pkg::DEN_W'(shunt);
    end
  end

  // range decision
  logic [1:0]  active_next, prior_next, res_range_next, res_status_next;
  logic        ovf_next, res_sat_next;
  logic [2:0]  waiting_next, drive_next;
  logic [15:0] timer_next [3];

  always_comb begin
    logic [2:0]  ar;
    logic [16:0] t_sum;
    logic        pending;
    logic [10:0] clear_at;
    clear_at        = 11'(recovery_ms) + 11'(settle_ms);
    active_next     = active_range;
    prior_next      = prior_range;
    ovf_next        = overflowed;
    waiting_next    = waiting;
    drive_next      = drive;
    res_sat_next    = (refs == 12'd0) || (den == '0);
    res_status_next = (refs == 12'd0) ? acm_pkg::ST_REF_ZERO : acm_pkg::ST_OK;
    res_range_next  = acm_pkg::RANGE_OVF;
    ar              = {1'b0, active_range};
    for (int i = 0; i < 3; i++) begin
      t_sum         = {1'b0, timer[i]} + {1'b0, acm_pkg::TICK_MS};
      timer_next[i] = timer[i];
      if (waiting[i] && !overflowed)
        timer_next[i] = t_sum[16] ? acm_pkg::TIMER_MAX : t_sum[15:0];
    end
    pending = |waiting;
    if (byp) ar = 3'd2;
    else begin
      if (mean > up_th && !pending) ar = ar + 3'd1;
      if (mean < down_th && ar != 3'd0 && !pending) ar = ar - 3'd1;
    end
    if (overflowed || ar > 3'd2) begin
      ovf_next        = 1'b1;
      active_next     = acm_pkg::RANGE_OVF;
      drive_next      = 3'b000;
      res_sat_next    = 1'b1;
      res_status_next = acm_pkg::ST_OVERFLOW;
    end else begin
      active_next = ar[1:0];
      if (ar[1:0] != prior_range) begin
        drive_next[ar[1:0]]    = 1'b1;
        waiting_next[ar[1:0]]  = 1'b0;
        timer_next[ar[1:0]]    = '0;
        timer_next[prior_range] = '0;
        waiting_next[prior_range] = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        if (waiting_next[i]) begin
          if (timer_next[i] >= 16'(recovery_ms)) drive_next[i] = 1'b0;
          if (timer_next[i] >= 16'(clear_at)) begin
            timer_next[i]   = '0;
            waiting_next[i] = 1'b0;
          end
        end
      end
      prior_next     = ar[1:0];
      res_range_next = ar[1:0];
    end
  end

  logic       res_sat;
  logic [1:0] res_range, res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_range <= acm_pkg::RANGE_HIGH;
      prior_range  <= acm_pkg::RANGE_HIGH;
      overflowed   <= 1'b0;
      waiting      <= '0;
      drive        <= 3'b100;
      for (int i = 0; i < 3; i++) timer[i] <= '0;
    end else if (cmd.decide) begin
      active_range <= active_next;
      prior_range  <= prior_next;
      overflowed   <= ovf_next;
      waiting      <= waiting_next;
      drive        <= drive_next;
      for (int i = 0; i < 3; i++) timer[i] <= timer_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_sat    <= res_sat_next;
      res_range  <= res_range_next;
      res_status <= res_status_next;
    end
  end

  // divider
  logic                      div_done;
  logic [acm_pkg::NUM_W-1:0] quot;

  acm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.decide),
    .dividend (num),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      current_ua <= (res_sat || (|quot[acm_pkg::NUM_W-1:32])) ? 32'hFFFF_FFFF : quot[31:0];
      range_now  <= res_range;
      relays     <= drive;
      status     <= res_status;
    end
  end

  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ----- rtl/autorange_current_meter_core.sv -----
`default_nettype none
// Autoranging current meter over three shunt ranges.
// Input items arrive on the s_ stream: one current sample, one reference
// sample and the bypass level per tick. Each item yields exactly one result
// item on the m_ stream: current in microamps, the range in use, the three
// relay drives and a status code.
// Registers are to be written and read over the APB-style port only while
// the block is idle; the user keeps this, the block does not enforce it.
// pready is always high. One item is in work at a time: the sequencer runs
// the sample ring update, the mean, the numerator and denominator products
// and the range decision, waits for the restoring divider, which produces
// one of 44 quotient bits per cycle, then loads the output register.
// s_tready is high only while the sequencer waits for an item.
// The result sits in an output register; when the receiver stalls the next
// item is still taken and worked on, and its result waits until the
// register is free.
// Reset loads the register defaults, clears the sample ring, selects the
// high range with only its relay closed, and drops m_tvalid.
module autorange_current_meter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // current_sample, ref_sample
  input  wire logic        s_tuser,   // bypass
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // current_ua, range_now, relay_low,
                                      // relay_mid, relay_high, status, zero pad
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  acm_pkg::cmd_t  cmd;
  acm_pkg::stat_t stat;
  logic [31:0] current_ua;
  logic [1:0]  range_now, status;
  logic [2:0]  relays;

  assign pready = 1'b1;

  acm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .current_sample (s_tdata[11:0]),
    .ref_sample     (s_tdata[23:12]),
    .bypass         (s_tuser),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .current_ua     (current_ua),
    .range_now      (range_now),
    .relays         (relays),
    .status         (status),
    .cfg_write      (psel && penable && pwrite),
    .cfg_index      (paddr[4:2]),
    .cfg_data       (pwdata),
    .cfg_rdata      (prdata)
  );

  assign m_tdata = {1'b0, status, relays, range_now, current_ua};

  // result valid drops right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while busy");

  // overflow opens all relays and reports overflow status
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] == acm_pkg::RANGE_OVF) |->
      (m_tdata[36:34] == 3'b000) && (m_tdata[38:37] == acm_pkg::ST_OVERFLOW)
      && (m_tdata[31:0] == 32'hFFFF_FFFF))
    else $error("overflow result inconsistent");

  // overflow status only with overflow range
  a_ovf_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[38:37] == acm_pkg::ST_OVERFLOW) |->
      (m_tdata[33:32] == acm_pkg::RANGE_OVF))
    else $error("overflow status outside overflow range");

endmodule
`default_nettype wire
